// ----- hdl/tvd_flux_limiter_unit_defines.svh -----
// assertion macros for the tvd flux limiter unit
`ifndef TVD_FLUX_LIMITER_UNIT_DEFINES_SVH
`define TVD_FLUX_LIMITER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define TVD_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define TVD_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, always checked
`define TVD_AST_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tvdfl_pkg.sv -----
// shared types and constants for the tvd flux limiter unit
package tvdfl_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 16;
  localparam int KIND_W        = 4;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [KIND_W-1:0] {
    LK_SB_FLUX  = 4'd0,
    LK_BA_FLUX  = 4'd1,
    LK_VL_FLUX  = 4'd2,
    LK_VA_FLUX  = 4'd3,
    LK_MM_FLUX  = 4'd4,
    LK_SB_SLOPE = 4'd5,
    LK_BA_SLOPE = 4'd6,
    LK_VL_SLOPE = 4'd7,
    LK_VA_SLOPE = 4'd8,
    LK_MM_SLOPE = 4'd9,
    LK_ZERO     = 4'd10
  } lk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- hdl/tvdfl_fifo.sv -----
// small register queue with full and empty status
module tvdfl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output tvdfl_pkg::fifo_stat_t stat
);
  import tvdfl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/tvdfl_front.sv -----
// front end: kind register, sign test, limiter select and squares
module tvdfl_front #(
  parameter int FRAC_BITS = tvdfl_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = tvdfl_pkg::INT_BITS_DEF,
  parameter int EW        = tvdfl_pkg::KIND_W + 5 * (INT_BITS + FRAC_BITS) - 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tvdfl_pkg::KIND_W-1:0]         limiter_kind,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] ratio,
  output logic [EW-1:0]                        entry
);
  import tvdfl_pkg::*;

  localparam int RW = INT_BITS + FRAC_BITS;
  localparam int DW = 2 * RW;
  localparam logic [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;

  logic [KIND_W-1:0] kind_reg;
  logic [RW-2:0] r;
  logic [RW-1:0] rp1;
  logic [DW-1:0] rsq;
  logic [DW-1:0] rp1sq;
  logic pos;
  lk_t op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_reg <= '0;
    end else if (cfg_valid) begin
      kind_reg <= limiter_kind;
    end
  end

  assign r     = ratio[RW-2:0];
  assign pos   = !ratio[RW-1] && (r != '0);
  assign rp1   = {1'b0, r} + ONE_R;
  assign rsq   = DW'(r) * DW'(r);
  assign rp1sq = DW'(rp1) * DW'(rp1);

  always_comb begin
    if (pos && (kind_reg <= KIND_W'(LK_MM_SLOPE))) begin
      op = lk_t'(kind_reg);
    end else begin
      op = LK_ZERO;
    end
  end

  assign entry = {op, r, rsq, rp1sq};

endmodule

// ----- hdl/tvdfl_back.sv -----
// back end: operand setup, two-lane bit-per-stage divider, final select
module tvdfl_back #(
  parameter int FRAC_BITS = tvdfl_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = tvdfl_pkg::INT_BITS_DEF,
  parameter int EW        = tvdfl_pkg::KIND_W + 5 * (INT_BITS + FRAC_BITS) - 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [EW-1:0]            entry,
  input  tvdfl_pkg::fifo_stat_t    in_stat,
  output logic                     in_pop,
  input  tvdfl_pkg::fifo_stat_t    out_stat,
  output logic                     out_push,
  output logic [FRAC_BITS+1:0]     out_phi
);
  import tvdfl_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int RW   = INT_BITS + FRAC_BITS;
  localparam int DW   = 2 * RW;
  localparam int PW   = F + 2;
  localparam int NSTG = F + 2;
  localparam int L    = NSTG - 1;
  localparam logic [RW:0] ONE_R = (RW+1)'(1) << F;
  localparam logic [RW:0] TWO_R = (RW+1)'(2) << F;
  localparam logic [PW-1:0] ONE_P = PW'(1) << F;
  localparam logic [PW-1:0] TWO_P = PW'(2) << F;
  localparam logic [DW-1:0] ONE_SQ = DW'(1) << (2 * F);

  logic en;

  lk_t               e_op;
  logic [KIND_W-1:0] e_kind;
  logic [RW-2:0]  e_r;
  logic [DW-1:0]  e_rsq;
  logic [DW-1:0]  e_rp1sq;
  logic [RW:0]    rw;
  logic [RW:0]    r2;
  logic [RW:0]    rp1;
  logic [RW:0]    mx;
  logic [RW:0]    sf;
  logic [RW:0]    ba;
  logic [RW:0]    mm;
  logic [PW-1:0]  dir_next;
  logic [DW-1:0]  d_next;
  logic [DW-1:0]  na_next;
  logic [DW-1:0]  nb_next;

  logic           vld   [NSTG];
  lk_t            op_s  [NSTG];
  logic [PW-1:0]  dir_s [NSTG];
  logic [DW-1:0]  d_s   [NSTG];
  logic [DW-1:0]  a_s   [NSTG];
  logic [DW-1:0]  b_s   [NSTG];
  logic [F:0]     qa_s  [NSTG];
  logic [F:0]     qb_s  [NSTG];
  logic           sa_s  [NSTG];
  logic           sb_s  [NSTG];

  logic [PW-1:0]  va;
  logic [PW-1:0]  vb;
  logic [PW-1:0]  res;

  assign en     = !out_stat.full;
  assign in_pop = en && !in_stat.empty;

  assign {e_kind, e_r, e_rsq, e_rp1sq} = entry;
  assign e_op = lk_t'(e_kind);

  // operand setup
  always_comb begin
    rw  = {2'b00, e_r};
    r2  = rw << 1;
    rp1 = rw + ONE_R;
    mx  = (rw > ONE_R) ? rw : ONE_R;
    if (mx > TWO_R) begin
      mx = TWO_R;
    end
    sf = (r2 < mx) ? r2 : mx;
    ba = rp1 >> 1;
    if (r2 < ba) begin
      ba = r2;
    end
    if (TWO_R < ba) begin
      ba = TWO_R;
    end
    mm = (rw < ONE_R) ? rw : ONE_R;
  end

  always_comb begin
    dir_next = '0;
    d_next   = DW'(rp1);
    na_next  = '0;
    nb_next  = '0;
    unique case (e_op)
      LK_SB_FLUX: dir_next = sf[PW-1:0];
      LK_BA_FLUX: dir_next = ba[PW-1:0];
      LK_MM_FLUX: dir_next = mm[PW-1:0];
      LK_VL_FLUX: na_next = DW'(r2);
      LK_VA_FLUX: begin
        na_next = e_rsq + (DW'(rw) << F);
        d_next  = e_rsq + ONE_SQ;
      end
      LK_SB_SLOPE: na_next = DW'(sf) << 1;
      LK_BA_SLOPE: begin
        na_next = DW'(ONE_R) << 2;
        nb_next = DW'(rw) << 2;
      end
      LK_VL_SLOPE: begin
        na_next = DW'(rw) << (F + 2);
        d_next  = e_rp1sq;
      end
      LK_VA_SLOPE: begin
        na_next = DW'(rw) << (F + 1);
        d_next  = e_rsq + ONE_SQ;
      end
      LK_MM_SLOPE: begin
        na_next = DW'(ONE_R) << 1;
        nb_next = DW'(r2);
      end
      default: dir_next = '0;
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= !in_stat.empty;
      for (int k = 1; k < NSTG; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_s[0]  <= e_op;
      dir_s[0] <= dir_next;
      d_s[0]   <= d_next;
      a_s[0]   <= na_next;
      b_s[0]   <= nb_next;
      qa_s[0]  <= '0;
      qb_s[0]  <= '0;
      sa_s[0]  <= 1'b0;
      sb_s[0]  <= 1'b0;
    end
  end

  // integer bit and saturation test
  always_ff @(posedge clk) begin
    if (en) begin
      op_s[1]  <= op_s[0];
      dir_s[1] <= dir_s[0];
      d_s[1]   <= d_s[0];
      sa_s[1]  <= {1'b0, a_s[0]} >= {d_s[0], 1'b0};
      sb_s[1]  <= {1'b0, b_s[0]} >= {d_s[0], 1'b0};
      qa_s[1]  <= {qa_s[0][F-1:0], a_s[0] >= d_s[0]};
      qb_s[1]  <= {qb_s[0][F-1:0], b_s[0] >= d_s[0]};
      a_s[1]   <= (a_s[0] >= d_s[0]) ? a_s[0] - d_s[0] : a_s[0];
      b_s[1]   <= (b_s[0] >= d_s[0]) ? b_s[0] - d_s[0] : b_s[0];
    end
  end

  // fraction bits, one per stage
  for (genvar k = 2; k < NSTG; k++) begin : g_div
    logic [DW:0] ta;
    logic [DW:0] tb;
    logic [DW:0] ta_sub;
    logic [DW:0] tb_sub;
    logic        ga;
    logic        gb;

    always_comb begin
      ta     = {a_s[k-1], 1'b0};
      tb     = {b_s[k-1], 1'b0};
      ta_sub = ta - {1'b0, d_s[k-1]};
      tb_sub = tb - {1'b0, d_s[k-1]};
      ga     = ta >= {1'b0, d_s[k-1]};
      gb     = tb >= {1'b0, d_s[k-1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op_s[k]  <= op_s[k-1];
        dir_s[k] <= dir_s[k-1];
        d_s[k]   <= d_s[k-1];
        sa_s[k]  <= sa_s[k-1];
        sb_s[k]  <= sb_s[k-1];
        qa_s[k]  <= {qa_s[k-1][F-1:0], ga};
        qb_s[k]  <= {qb_s[k-1][F-1:0], gb};
        a_s[k]   <= ga ? ta_sub[DW-1:0] : ta[DW-1:0];
        b_s[k]   <= gb ? tb_sub[DW-1:0] : tb[DW-1:0];
      end
    end
  end

  // final select
  always_comb begin
    va  = sa_s[L] ? TWO_P : {1'b0, qa_s[L]};
    vb  = sb_s[L] ? TWO_P : {1'b0, qb_s[L]};
    res = va;
    unique case (op_s[L])
      LK_SB_FLUX, LK_BA_FLUX, LK_MM_FLUX, LK_ZERO: res = dir_s[L];
      LK_BA_SLOPE: begin
        if (vb < res) begin
          res = vb;
        end
        if (ONE_P < res) begin
          res = ONE_P;
        end
      end
      LK_MM_SLOPE: begin
        if (vb < res) begin
          res = vb;
        end
      end
      default: res = va;
    endcase
  end

  assign out_push = en && vld[L];
  assign out_phi  = res;

endmodule

// ----- hdl/tvd_flux_limiter_unit.sv -----
// top level of the tvd flux limiter unit
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------
//  input    | push / full            | ratio  (signed Q16.16)
//  result   | pop / empty            | phi    (unsigned Q2.16)
//  config   | cfg_valid / cfg_ready  | limiter_kind (4 bits)
//
// one request per cycle in and out; the divider adds one stage per quotient bit
// a request passes the input queue, the divider stages and then the result queue
// the divider pipeline halts only while the result queue is full
// synchronous reset empties both queues and sets the stored limiter kind to 0
// cfg_ready is always high
module tvd_flux_limiter_unit #(
  parameter int FRAC_BITS = tvdfl_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = tvdfl_pkg::INT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] ratio,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [FRAC_BITS+1:0]                 phi,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tvdfl_pkg::KIND_W-1:0]         limiter_kind
);
  import tvdfl_pkg::*;

  localparam int RW = INT_BITS + FRAC_BITS;
  localparam int EW = KIND_W + 5 * RW - 1;
  localparam int PW = FRAC_BITS + 2;

  logic [EW-1:0] fe_entry;
  logic [EW-1:0] mq_entry;
  fifo_stat_t    mq_stat;
  fifo_stat_t    oq_stat;
  logic          mq_pop;
  logic          oq_push;
  logic [PW-1:0] oq_phi;

  tvdfl_front #(
    .FRAC_BITS(FRAC_BITS),
    .INT_BITS (INT_BITS),
    .EW       (EW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .limiter_kind(limiter_kind),
    .ratio       (ratio),
    .entry       (fe_entry)
  );

  tvdfl_fifo #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(fe_entry),
    .pop  (mq_pop),
    .rdata(mq_entry),
    .stat (mq_stat)
  );

  tvdfl_back #(
    .FRAC_BITS(FRAC_BITS),
    .INT_BITS (INT_BITS),
    .EW       (EW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .entry   (mq_entry),
    .in_stat (mq_stat),
    .in_pop  (mq_pop),
    .out_stat(oq_stat),
    .out_push(oq_push),
    .out_phi (oq_phi)
  );

  tvdfl_fifo #(
    .WIDTH(PW),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (oq_push),
    .wdata(oq_phi),
    .pop  (pop),
    .rdata(phi),
    .stat (oq_stat)
  );

  assign full  = mq_stat.full;
  assign empty = oq_stat.empty;

endmodule

// ----- hdl/tvdfl_chk.sv -----
// port checker for the tvd flux limiter unit and its bind
`include "tvd_flux_limiter_unit_defines.svh"

module tvdfl_chk #(
  parameter int FRAC_BITS = tvdfl_pkg::FRAC_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic [FRAC_BITS+1:0] phi
);
  localparam logic [FRAC_BITS+1:0] TWO_P = (FRAC_BITS+2)'(2) << FRAC_BITS;

  // result never above 2.0
  `TVD_AST_IMP(a_phi_range, !empty, phi <= TWO_P, "phi above 2.0")

  // reset leaves both queues empty
  `TVD_AST_RST(a_reset_clear, rst, empty && !full, "queues not clear after reset")

  // waiting result holds until popped
  `TVD_AST_NXT(a_hold, !empty && !pop, !empty && $stable(phi), "waiting result changed")

endmodule

bind tvd_flux_limiter_unit tvdfl_chk #(
  .FRAC_BITS(FRAC_BITS)
) u_chk (
  .clk  (clk),
  .rst  (rst),
  .full (full),
  .empty(empty),
  .pop  (pop),
  .phi  (phi)
);
